@@ rtl/core/fda_pkg.sv @@
// types and constants shared by the fixed point to decimal text converter
// no dependencies
package fda_pkg;

  typedef struct packed {
    logic signed [31:0] value;
    logic [3:0]         places;
  } fda_num_t;

  typedef struct packed {
    logic [7:0] character;
    logic       last;
  } fda_chr_t;

  typedef struct packed {
    logic     valid;
    fda_chr_t chr;
  } fda_emit_t;

  // at most ten digits: 2^32-1 has ten, padding needs places+1
  localparam int unsigned DIG_N  = 10;
  localparam int unsigned PROD_W = 64;

  // floor(x / 10) == (x * RECIP_TEN) >> RECIP_SHIFT for any 32-bit x
  localparam logic [31:0] RECIP_TEN   = 32'hCCCC_CCCD;
  localparam int unsigned RECIP_SHIFT = 35;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_MINUS = 8'h2D;

  function automatic logic [31:0] pow_ten(input logic [3:0] p);
    logic [31:0] r;
    case (p)
      4'd0:    r = 32'd1;
      4'd1:    r = 32'd10;
      4'd2:    r = 32'd100;
      4'd3:    r = 32'd1000;
      4'd4:    r = 32'd10000;
      4'd5:    r = 32'd100000;
      4'd6:    r = 32'd1000000;
      4'd7:    r = 32'd10000000;
      4'd8:    r = 32'd100000000;
      4'd9:    r = 32'd1000000000;
      default: r = 32'd1;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/core/fda_mul.sv @@
// shared 32 x 32 multiplier with a registered product
// depends on fda_pkg
module fda_mul (
  input  logic                        clk,
  input  logic [31:0]                 a,
  input  logic [31:0]                 b,
  output logic [fda_pkg::PROD_W-1:0]  prod
);
  import fda_pkg::*;

  always_ff @(posedge clk) begin
    prod <= PROD_W'(a) * PROD_W'(b);
  end

endmodule

@@ rtl/core/fda_seq.sv @@
// sequencer: scaling, digit extraction by reciprocal multiply, character emission
// depends on fda_pkg, drives the shared multiplier fda_mul
module fda_seq #(
  parameter int FRAC_BITS  = 16,
  parameter int MAX_PLACES = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  fda_pkg::fda_num_t           num,
  input  logic                        out_free,
  output logic                        busy,
  output fda_pkg::fda_emit_t          emit,
  output logic [31:0]                 mul_a,
  output logic [31:0]                 mul_b,
  input  logic [fda_pkg::PROD_W-1:0]  prod
);
  import fda_pkg::*;

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_SCALE_MUL = 4'd1;
  localparam logic [3:0] S_SCALE_ADD = 4'd2;
  localparam logic [3:0] S_SAT       = 4'd3;
  localparam logic [3:0] S_DIV_MUL   = 4'd4;
  localparam logic [3:0] S_DIV_REM   = 4'd5;
  localparam logic [3:0] S_SIGN      = 4'd6;
  localparam logic [3:0] S_DOT       = 4'd7;
  localparam logic [3:0] S_DIGIT     = 4'd8;

  localparam logic [PROD_W-1:0] HALF =
    (FRAC_BITS == 0) ? PROD_W'(0) : (PROD_W'(1) << (FRAC_BITS - 1));
  localparam logic [3:0] MAX_P = 4'(MAX_PLACES);

  logic [3:0]        state;
  logic              neg;
  logic [31:0]       mag;
  logic [3:0]        plc;
  logic [PROD_W-1:0] acc;
  logic [31:0]       val;
  logic [3:0]        n;
  logic [3:0]        cnt;
  logic [3:0]        dig [DIG_N];

  logic [PROD_W-1:0] sh;
  logic [31:0]       quot;
  logic [31:0]       rem;
  logic [3:0]        ndig;
  logic [3:0]        idx;
  logic [3:0]        cur_dig;
  logic [3:0]        cnt_next;
  logic              can_emit;

  assign busy  = (state != S_IDLE);
  assign mul_a = (state == S_SCALE_MUL) ? mag : val;
  assign mul_b = (state == S_SCALE_MUL) ? pow_ten(plc) : RECIP_TEN;

  always_comb begin
    sh       = acc >> FRAC_BITS;
    quot     = 32'(prod >> RECIP_SHIFT);
    rem      = val - ((quot << 3) + (quot << 1));
    // integer digits plus zero padding, with a leading zero before the point
    ndig     = (n > plc) ? n : (plc + 4'd1);
    idx      = cnt - 4'd1;
    cur_dig  = (idx < n) ? dig[idx] : 4'd0;
    cnt_next = cnt - 4'd1;
    can_emit = out_free &&
               (state == S_SIGN || state == S_DOT || state == S_DIGIT);
  end

  always_comb begin
    emit.valid         = can_emit;
    emit.chr.last      = 1'b0;
    emit.chr.character = CH_ZERO + {4'd0, cur_dig};
    case (state)
      S_SIGN:  emit.chr.character = CH_MINUS;
      S_DOT:   emit.chr.character = CH_DOT;
      S_DIGIT: emit.chr.last      = (cnt == 4'd1);
      default: emit.chr.last      = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            neg   <= num.value[31];
            mag   <= num.value[31] ? (32'd0 - 32'(num.value)) : 32'(num.value);
            plc   <= (num.places > MAX_P) ? MAX_P : num.places;
            state <= S_SCALE_MUL;
          end
        end
        S_SCALE_MUL: state <= S_SCALE_ADD;
        S_SCALE_ADD: begin
          acc   <= prod + HALF;
          state <= S_SAT;
        end
        S_SAT: begin
          val   <= (|sh[PROD_W-1:32]) ? 32'hFFFF_FFFF : sh[31:0];
          n     <= 4'd0;
          state <= S_DIV_MUL;
        end
        S_DIV_MUL: begin
          if (val == 32'd0) begin
            cnt   <= ndig;
            state <= neg ? S_SIGN : S_DIGIT;
          end else begin
            state <= S_DIV_REM;
          end
        end
        S_DIV_REM: begin
          dig[n] <= rem[3:0];
          n      <= n + 4'd1;
          val    <= quot;
          state  <= S_DIV_MUL;
        end
        S_SIGN: begin
          if (out_free) state <= S_DIGIT;
        end
        S_DOT: begin
          if (out_free) state <= S_DIGIT;
        end
        S_DIGIT: begin
          if (out_free) begin
            cnt <= cnt_next;
            if (cnt_next == 4'd0) state <= S_IDLE;
            else if (cnt_next == plc) state <= S_DOT;
            else state <= S_DIGIT;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/core/fixed_to_decimal_ascii.sv @@
// signed fixed point to decimal ascii text, one character per output transfer
// after an input transfer the sequencer scales on the shared multiplier, adds the
// rounding half and saturates, then takes one reciprocal multiply and remainder step per
// significant digit of the scaled magnitude (0..10), then emits 1..12 characters;
// a new number is stalled until the last character has gone to the output register
// reset clears the sequencer and the output valid; busy numbers are dropped
// depends on fda_pkg, fda_mul, fda_seq
module fixed_to_decimal_ascii #(
  parameter int FRAC_BITS  = 16,
  parameter int MAX_PLACES = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              num_valid,
  output logic              num_stall,
  input  fda_pkg::fda_num_t num,
  output logic              chr_valid,
  input  logic              chr_stall,
  output fda_pkg::fda_chr_t chr
);
  import fda_pkg::*;

  logic              busy;
  logic              start;
  logic              out_free;
  fda_emit_t         emit;
  logic [31:0]       mul_a;
  logic [31:0]       mul_b;
  logic [PROD_W-1:0] prod;

  assign num_stall = busy;
  assign start     = num_valid && !busy;
  // output register can take a character when empty or being drained
  assign out_free  = !chr_valid || !chr_stall;

  fda_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  fda_seq #(
    .FRAC_BITS  (FRAC_BITS),
    .MAX_PLACES (MAX_PLACES)
  ) u_seq (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .num      (num),
    .out_free (out_free),
    .busy     (busy),
    .emit     (emit),
    .mul_a    (mul_a),
    .mul_b    (mul_b),
    .prod     (prod)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      chr_valid <= 1'b0;
    end else if (emit.valid) begin
      chr_valid <= 1'b1;
    end else if (!chr_stall) begin
      chr_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.valid) chr <= emit.chr;
  end

endmodule

@@ test/fixed_to_decimal_ascii_tb.sv @@
// testbench for fixed_to_decimal_ascii: directed table then random numbers, with random
// gaps on both sides and long output holds, checked against typed text or a local formatter
// depends on fda_pkg and the fixed_to_decimal_ascii rtl
`timescale 1ns / 1ps

module fixed_to_decimal_ascii_tb;
  import fda_pkg::*;

  localparam int FRAC_BITS    = 16;
  localparam int MAX_PLACES   = 8;
  localparam int PERIOD       = 10;
  localparam int RANDOM_ITEMS = 450;
  localparam int LONG_HOLD    = 400;
  localparam int QUIET_LIMIT  = 4000;
  localparam int SETTLE       = 60;

  // typed holds the expected text right justified, all zero means use the formatter
  typedef struct packed {
    logic [31:0] value;
    logic [3:0]  places;
    logic [95:0] typed;
  } number_row_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      num_valid = 1'b0;
  logic      num_stall;
  fda_num_t  num = '0;
  logic      chr_valid;
  logic      chr_stall = 1'b0;
  fda_chr_t  chr;

  logic [95:0] num_typed = '0;
  logic        calm = 1'b0;
  int          nums_taken = 0;
  int          quiet_cycles = 0;
  int          failures = 0;
  fda_chr_t    expected_chars [$];

  fixed_to_decimal_ascii #(
    .FRAC_BITS (FRAC_BITS),
    .MAX_PLACES(MAX_PLACES)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .num_valid(num_valid),
    .num_stall(num_stall),
    .num      (num),
    .chr_valid(chr_valid),
    .chr_stall(chr_stall),
    .chr      (chr)
  );

  always #(PERIOD / 2) clk = ~clk;

  // text of one number, last character in the low byte
  function automatic logic [95:0] format_number(input logic [31:0] raw,
                                                input logic [3:0] req_places);
    logic [3:0]  p;
    logic [63:0] scale;
    logic [63:0] mag;
    logic [63:0] scaled;
    logic [31:0] a;
    logic [7:0]  digs [12];
    logic [95:0] line;
    int          n;
    p = (req_places > MAX_PLACES) ? 4'(MAX_PLACES) : req_places;
    scale = 64'd1;
    for (int i = 0; i < p; i++) scale = scale * 64'd10;
    mag = raw[31] ? (64'h1_0000_0000 - 64'(raw)) : 64'(raw);
    scaled = (mag * scale + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    a = (scaled > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : scaled[31:0];
    n = 0;
    while (a != 0) begin
      digs[n] = CH_ZERO + 8'(a % 10);
      a = a / 10;
      n++;
    end
    while (n < p) begin
      digs[n] = CH_ZERO;
      n++;
    end
    // leading zero before the point
    if (n == p) begin
      digs[n] = CH_ZERO;
      n++;
    end
    line = '0;
    if (raw[31]) line = {line[87:0], CH_MINUS};
    for (int i = n - 1; i >= 0; i--) begin
      if (i + 1 == p) line = {line[87:0], CH_DOT};
      line = {line[87:0], digs[i]};
    end
    return line;
  endfunction

  task automatic queue_text(input logic [95:0] line);
    fda_chr_t c;
    for (int i = 11; i >= 0; i--) begin
      if (line[i*8 +: 8] != 8'h00) begin
        c.character = line[i*8 +: 8];
        c.last      = (i == 0);
        expected_chars.push_back(c);
      end
    end
  endtask

  task automatic check_char(input fda_chr_t got);
    fda_chr_t want;
    if (expected_chars.size() == 0) begin
      failures++;
      if (failures <= 10)
        $display("unexpected character '%c' (%h) last %0b", got.character, got.character,
                 got.last);
    end else begin
      want = expected_chars.pop_front();
      if (got.character !== want.character || got.last !== want.last) begin
        failures++;
        if (failures <= 10)
          $display("mismatch: expected '%c' (%h) last %0b, got '%c' (%h) last %0b",
                   want.character, want.character, want.last,
                   got.character, got.character, got.last);
      end
    end
  endtask

  // predictions are made when the number transfer happens
  always @(posedge clk) begin
    if (!rst) begin
      if (num_valid && !num_stall) begin
        nums_taken <= nums_taken + 1;
        queue_text((num_typed != '0) ? num_typed : format_number(num.value, num.places));
      end
      if (chr_valid && !chr_stall) check_char(chr);
      if ((num_valid && !num_stall) || (chr_valid && !chr_stall)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("no transfer for %0d cycles", QUIET_LIMIT);
        $display("fixed_to_decimal_ascii_tb: FAIL");
        $finish;
      end
    end
  end

  // output side: random hold before each character, long holds while nums_taken is 120 or 121
  initial begin
    int hold;
    bool_hold_done: begin end
    hold = 0;
    wait (!rst);
    forever begin
      hold = calm ? 0 : $urandom_range(0, 7);
      if (hold >= 0 && nums_taken >= 120 && nums_taken < 122) hold = LONG_HOLD;
      repeat (hold) begin
        @(negedge clk);
        chr_stall <= 1'b1;
      end
      @(negedge clk);
      chr_stall <= 1'b0;
      @(posedge clk);
      while (!chr_valid) @(posedge clk);
    end
  end

  task automatic offer_number(input logic [31:0] v, input logic [3:0] p,
                              input logic [95:0] typed);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 7);
    repeat (gap) begin
      @(negedge clk);
      num_valid <= 1'b0;
    end
    @(negedge clk);
    num_valid <= 1'b1;
    num       <= '{value: v, places: p};
    num_typed <= typed;
    @(posedge clk);
    while (num_stall) @(posedge clk);
  endtask

  task automatic random_number(output logic [31:0] v, output logic [3:0] p);
    int          kind;
    logic [31:0] m;
    kind = $urandom_range(0, 99);
    p = 4'($urandom_range(0, MAX_PLACES));
    if (kind < 25) begin
      v = $urandom;
      p = 4'($urandom_range(0, 15));
    end else if (kind < 60) begin
      m = {16'($urandom_range(0, 999)), 16'($urandom)};
      v = $urandom_range(0, 1) ? -m : m;
    end else if (kind < 75) begin
      // fraction lands exactly on half of the last place
      m = {16'($urandom_range(0, 99)),
           16'(((($urandom_range(0, (1 << p) - 1)) << 1) | 1) << (15 - p))};
      v = $urandom_range(0, 1) ? -m : m;
    end else if (kind < 85) begin
      v = -32'($urandom_range(1, 2000));
    end else begin
      v = {$urandom_range(0, 1) ? 2'b10 : 2'b01, 30'($urandom)};
      p = 4'($urandom_range(4, 15));
    end
  endtask

  initial begin
    number_row_t rows [24];
    logic [31:0] v;
    logic [3:0]  p;
    rows = '{
      '{32'h0000_0000, 4'd0,  "0"},
      '{32'h0000_0000, 4'd2,  "0.00"},
      '{32'h0000_0000, 4'd8,  "0.00000000"},
      '{32'h0001_0000, 4'd0,  "1"},
      '{32'hFFFF_0000, 4'd0,  "-1"},
      '{32'hFFFF_FFFF, 4'd2,  "-0.00"},
      '{32'h0000_8000, 4'd0,  "1"},
      '{32'h0000_7FFF, 4'd0,  "0"},
      '{32'hFFFF_8000, 4'd0,  "-1"},
      '{32'h7FFF_FFFF, 4'd0,  "32768"},
      '{32'h8000_0000, 4'd0,  "-32768"},
      '{32'h7FFF_FFFF, 4'd8,  "42.94967295"},
      '{32'h8000_0000, 4'd8,  "-42.94967295"},
      '{32'h0001_0000, 4'd15, "1.00000000"},
      '{32'h0001_0000, 4'd9,  "1.00000000"},
      '{32'h0000_4000, 4'd1,  "0.3"},
      '{32'hFFFF_C000, 4'd1,  "-0.3"},
      '{32'h0000_0001, 4'd8,  '0},
      '{32'h0003_243F, 4'd4,  '0},
      '{32'hFFFC_DBC1, 4'd5,  '0},
      '{32'h0000_1000, 4'd1,  '0},
      '{32'h1234_5678, 4'd3,  '0},
      '{32'h7FFF_FFFF, 4'd5,  '0},
      '{32'h7FFF_FFFF, 4'd6,  '0}
    };
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    foreach (rows[i]) offer_number(rows[i].value, rows[i].places, rows[i].typed);
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      // a stretch with back to back transfers on both sides
      calm = (i >= 250 && i < 310);
      random_number(v, p);
      offer_number(v, p, '0);
    end
    @(negedge clk);
    num_valid <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (failures == 0) begin
      $display("fixed_to_decimal_ascii_tb: PASS");
    end else begin
      $display("fixed_to_decimal_ascii_tb: FAIL");
    end
    $finish;
  end

endmodule
